[hw/rtl/dscag_pkg.sv]
// ----------------------------------------------------------------------------
// dscag_pkg
// Shared types and constants for the DAC sample converter and activity gate.
// ----------------------------------------------------------------------------
package dscag_pkg;

  // Default counter widths
  localparam int unsigned CHUNK_COUNT_BITS_DEF = 10;
  localparam int unsigned QUIET_COUNT_BITS_DEF = 16;

  // Configuration register widths and reset values
  localparam int unsigned ChunkSizeWidth = 10;
  localparam int unsigned ThresholdWidth = 15;
  localparam logic [ChunkSizeWidth-1:0] ChunkSizeReset = 10'd1000;
  localparam logic [ThresholdWidth-1:0] ThresholdReset = 15'd2;

  // Register indexes (byte address 4*i)
  localparam int unsigned PaddrWidth = 3;
  localparam logic [0:0] RegChunkSize = 1'b0;
  localparam logic [0:0] RegThreshold = 1'b1;

  // Item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindStart  = 1'b1;

  // Conversion constants
  localparam logic [12:0] SampleMask   = 13'h1fff;
  localparam logic signed [13:0] PcmOffset = 14'sh0fe0;

  // Queue depth between front and back
  localparam int unsigned FifoDepth = 2;

  typedef struct packed {
    logic        kind;
    logic [15:0] raw_word;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               audible;
    logic               chunk_release;
    logic               heard_any;
    logic [15:0]        quiet_run;
  } out_item_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic               kind;
    logic signed [15:0] pcm;
    logic               loud;
  } fe_item_t;

endpackage

[hw/rtl/dac_sample_convert_activity_gate_core.sv]
// ----------------------------------------------------------------------------
// dac_sample_convert_activity_gate_core
// Converts raw speech words to PCM and gates chunk release on audio activity.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  in        input      in_valid_i / in_ready_o     in_data_i  (kind, raw_word)
//  out       output     out_valid_o / out_ready_i   out_data_o (pcm, flags, quiet_run)
//  config    input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  One transaction per clock sustained while the output is ready. An
//  accepted input passes through a front register that holds the converted
//  sample, a 2-entry queue between it and the back, and the back's result
//  register that holds the output. The state is updated in the back. Reset
//  loads the register defaults and clears the valid flags, pointers and counters.
//  An output stall fills the queue first; input ready drops once both the
//  queue and the front register are full.
// ----------------------------------------------------------------------------
module dac_sample_convert_activity_gate_core import dscag_pkg::*; #(
  parameter int unsigned CHUNK_COUNT_BITS = CHUNK_COUNT_BITS_DEF,
  parameter int unsigned QUIET_COUNT_BITS = QUIET_COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [ChunkSizeWidth-1:0] chunk_size_q;
  logic [ThresholdWidth-1:0] threshold_q;
  logic [0:0]                reg_idx;
  logic                      wr_en;
  logic                      fe_valid, fe_ready;
  fe_item_t                  fe_item;
  logic                      bk_valid, bk_ready;
  fe_item_t                  bk_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= ChunkSizeReset;
      threshold_q  <= ThresholdReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegChunkSize: chunk_size_q <= pwdata[ChunkSizeWidth-1:0];
        RegThreshold: threshold_q  <= pwdata[ThresholdWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegChunkSize: prdata = 32'(chunk_size_q);
      RegThreshold: prdata = 32'(threshold_q);
      default:      prdata = '0;
    endcase
  end

  dscag_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .threshold_i (threshold_q),
    .fe_valid_o  (fe_valid),
    .fe_ready_i  (fe_ready),
    .fe_item_o   (fe_item)
  );

  dscag_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_item_i  (fe_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  dscag_back #(
    .CHUNK_COUNT_BITS (CHUNK_COUNT_BITS),
    .QUIET_COUNT_BITS (QUIET_COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chunk_size_i (chunk_size_q),
    .fe_valid_i   (bk_valid),
    .fe_ready_o   (bk_ready),
    .fe_item_i    (bk_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

[hw/rtl/dscag_front.sv]
// ----------------------------------------------------------------------------
// dscag_front
// Accepts raw words, converts them to PCM and classifies them as audible.
// ----------------------------------------------------------------------------
module dscag_front import dscag_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  in_item_t                  in_data_i,
  input  logic [ThresholdWidth-1:0] threshold_i,
  output logic                      fe_valid_o,
  input  logic                      fe_ready_i,
  output fe_item_t                  fe_item_o
);

  logic                valid_q, valid_d;
  fe_item_t            item_q, item_d;
  logic [15:0]         rev;
  logic [12:0]         samp;
  logic signed [13:0]  diff;
  logic signed [17:0]  prod;
  logic signed [17:0]  halved;
  logic signed [15:0]  pcm;
  logic [15:0]         mag;

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      rev[15-b] = in_data_i.raw_word[b];
    end
    samp   = rev[12:0] & SampleMask;
    diff   = $signed({1'b0, samp}) - PcmOffset;
    // times 15 as (x << 4) - x
    prod   = ($signed({{4{diff[13]}}, diff}) <<< 4) - $signed({{4{diff[13]}}, diff});
    // halve with truncation toward zero
    halved = (prod + (prod[17] ? 18'sd1 : 18'sd0)) >>> 1;
    pcm    = halved[15:0];
    mag    = pcm[15] ? (16'd0 - pcm) : pcm;
  end

  assign in_ready_o = !valid_q || fe_ready_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_valid_i && in_ready_o) begin
      valid_d     = 1'b1;
      item_d.kind = in_data_i.kind;
      if (in_data_i.kind == KindStart) begin
        item_d.pcm  = '0;
        item_d.loud = 1'b0;
      end else begin
        item_d.pcm  = pcm;
        item_d.loud = (mag[14:0] > threshold_i);
      end
    end else if (fe_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign fe_valid_o = valid_q;
  assign fe_item_o  = item_q;

endmodule

[hw/rtl/dscag_fifo.sv]
// ----------------------------------------------------------------------------
// dscag_fifo
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dscag_fifo import dscag_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  fe_item_t push_item_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output fe_item_t pop_item_o
);

  localparam int unsigned PtrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntWidth = $clog2(FifoDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(FifoDepth - 1);

  fe_item_t            entry_q [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntWidth'(FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/dscag_back.sv]
// ----------------------------------------------------------------------------
// dscag_back
// Updates the activity state per item and holds the result register.
// ----------------------------------------------------------------------------
module dscag_back import dscag_pkg::*; #(
  parameter int unsigned CHUNK_COUNT_BITS = CHUNK_COUNT_BITS_DEF,
  parameter int unsigned QUIET_COUNT_BITS = QUIET_COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ChunkSizeWidth-1:0] chunk_size_i,
  input  logic                      fe_valid_i,
  output logic                      fe_ready_o,
  input  fe_item_t                  fe_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output out_item_t                 out_data_o
);

  localparam int unsigned LimWidth =
      (CHUNK_COUNT_BITS > ChunkSizeWidth) ? CHUNK_COUNT_BITS : ChunkSizeWidth;
  localparam int unsigned QWidth = (QUIET_COUNT_BITS > 16) ? QUIET_COUNT_BITS : 16;
  localparam logic [LimWidth-1:0] CountMax = LimWidth'((64'd1 << CHUNK_COUNT_BITS) - 1);
  localparam logic [QUIET_COUNT_BITS-1:0] QuietMax = '1;

  logic [CHUNK_COUNT_BITS-1:0] pend_cnt_q, pend_cnt_d;
  logic                        pend_aud_q, pend_aud_d;
  logic                        heard_q, heard_d;
  logic [QUIET_COUNT_BITS-1:0] quiet_q, quiet_d;
  logic                        out_valid_q, out_valid_d;
  out_item_t                   out_q, out_d;

  logic [LimWidth-1:0]         size_ext;
  logic [CHUNK_COUNT_BITS-1:0] limit;
  logic [CHUNK_COUNT_BITS-1:0] cnt_inc;
  logic                        aud_new;
  logic                        release_hit;
  logic [QWidth-1:0]           quiet_ext;
  logic                        take;

  assign fe_ready_o = !out_valid_q || out_ready_i;
  assign take       = fe_valid_i && fe_ready_o;

  always_comb begin
    size_ext    = LimWidth'(chunk_size_i);
    limit       = (size_ext < CountMax) ? size_ext[CHUNK_COUNT_BITS-1:0]
                                        : CountMax[CHUNK_COUNT_BITS-1:0];
    cnt_inc     = (pend_cnt_q < limit) ? pend_cnt_q + 1'b1 : limit;
    aud_new     = pend_aud_q || fe_item_i.loud;
    release_hit = (cnt_inc >= limit) && aud_new;

    pend_cnt_d  = pend_cnt_q;
    pend_aud_d  = pend_aud_q;
    heard_d     = heard_q;
    quiet_d     = quiet_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (take) begin
      out_valid_d = 1'b1;
      if (fe_item_i.kind == KindStart) begin
        pend_cnt_d = '0;
        pend_aud_d = 1'b0;
        heard_d    = 1'b0;
        quiet_d    = '0;
      end else begin
        if (fe_item_i.loud) begin
          heard_d = 1'b1;
          quiet_d = '0;
        end else if (heard_q && (quiet_q != QuietMax)) begin
          quiet_d = quiet_q + 1'b1;
        end
        pend_cnt_d = release_hit ? '0 : cnt_inc;
        pend_aud_d = release_hit ? 1'b0 : aud_new;
      end
      quiet_ext           = QWidth'(quiet_d);
      out_d.pcm           = fe_item_i.pcm;
      out_d.audible       = fe_item_i.loud;
      out_d.chunk_release = (fe_item_i.kind == KindSample) && release_hit;
      out_d.heard_any     = heard_d;
      out_d.quiet_run     = (quiet_ext > QWidth'(17'hffff)) ? 16'hffff : quiet_ext[15:0];
    end else begin
      quiet_ext = QWidth'(quiet_q);
      if (out_ready_i) begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q  <= '0;
      pend_aud_q  <= 1'b0;
      heard_q     <= 1'b0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_cnt_q  <= pend_cnt_d;
      pend_aud_q  <= pend_aud_d;
      heard_q     <= heard_d;
      quiet_q     <= quiet_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/dac_sample_convert_activity_gate_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_sample_convert_activity_gate_core_tb
// Streams raw speech words and start-of-utterance items through the core and
// checks every result against an in-bench model of the PCM conversion, the
// activity gate and the chunk counter, across several register settings.
// ----------------------------------------------------------------------------
module dac_sample_convert_activity_gate_core_tb;
  import dscag_pkg::*;

  localparam int SilenceCode    = 'h0fe0;
  localparam int PcmGain        = 15;
  localparam int QuietMax       = 'hffff;
  localparam int LongHoldCycles = 400;

  typedef enum logic [1:0] {RxFree, RxRandom, RxPattern} rx_mode_e;
  typedef enum logic {TxStream, TxBursty} tx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PaddrWidth-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  dac_sample_convert_activity_gate_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model state and register copies
  logic [ChunkSizeWidth-1:0] chunk_cfg = ChunkSizeReset;
  logic [ThresholdWidth-1:0] thr_cfg = ThresholdReset;
  int   pend_cnt = 0;
  bit   pend_audio = 1'b0;
  bit   heard = 1'b0;
  int   quiet_cnt = 0;

  in_item_t  word_backlog[$];
  out_item_t awaited_samples[$];
  int        mismatch_count = 0;

  tx_mode_e  tx_mode = TxStream;
  rx_mode_e  rx_mode = RxFree;
  int        gap_left = 0;
  int        burst_left = 1;
  logic [7:0] rx_tick = '0;
  int        hold_left = 0;
  bit        hold_request = 1'b0;
  bit        hold_served = 1'b0;

  function automatic logic [15:0] mirror16(input logic [15:0] w);
    logic [15:0] r;
    for (int b = 0; b < 16; b++) r[15-b] = w[b];
    return r;
  endfunction

  // Advance the gate state by one transaction and return the result it yields
  function automatic out_item_t gate_sample(input in_item_t it);
    out_item_t r;
    int        code;
    int        pcm_val;
    int        mag;
    int        limit;
    bit        loud;
    bit        rel;
    r = '0;
    rel = 1'b0;
    if (it.kind == KindStart) begin
      pend_cnt = 0;
      pend_audio = 1'b0;
      heard = 1'b0;
      quiet_cnt = 0;
      return r;
    end
    code = int'(mirror16(it.raw_word) & 16'h1fff);
    pcm_val = ((code - SilenceCode) * PcmGain) / 2;
    mag = (pcm_val < 0) ? -pcm_val : pcm_val;
    loud = (mag > int'(thr_cfg));
    if (loud) begin
      heard = 1'b1;
      pend_audio = 1'b1;
      quiet_cnt = 0;
    end else if (heard && quiet_cnt < QuietMax) begin
      quiet_cnt++;
    end
    limit = int'(chunk_cfg);
    if (pend_cnt < limit) pend_cnt++;
    else pend_cnt = limit;
    if (pend_cnt >= limit && pend_audio) begin
      rel = 1'b1;
      pend_cnt = 0;
      pend_audio = 1'b0;
    end
    r.pcm = pcm_val[15:0];
    r.audible = loud;
    r.chunk_release = rel;
    r.heard_any = heard;
    r.quiet_run = quiet_cnt[15:0];
    return r;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Sender: streams back to back, or in bursty mode sends bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_backlog.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= word_backlog.pop_front();
        if (tx_mode == TxBursty) begin
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern per phase, plus one long hold-off on request
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 8'd1;
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      out_ready_i <= 1'b0;
      hold_left <= LongHoldCycles;
      hold_served <= 1'b1;
    end else begin
      case (rx_mode)
        RxFree:    out_ready_i <= 1'b1;
        RxRandom:  out_ready_i <= ($urandom_range(0, 9) < 6);
        default:   out_ready_i <= !(rx_tick[2:0] == 3'd5 || rx_tick[6:5] == 2'b11);
      endcase
    end
  end

  // Check results, then log each accepted input's expected result
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_samples.size() == 0) begin
          $error("unexpected result: pcm %0d", out_data_o.pcm);
          mismatch_count++;
        end else begin
          want = awaited_samples.pop_front();
          report_field("pcm", int'(want.pcm), int'(out_data_o.pcm));
          report_field("audible", want.audible, out_data_o.audible);
          report_field("chunk_release", want.chunk_release, out_data_o.chunk_release);
          report_field("heard_any", want.heard_any, out_data_o.heard_any);
          report_field("quiet_run", want.quiet_run, out_data_o.quiet_run);
        end
      end
      if (in_valid_i && in_ready_o)
        awaited_samples = {awaited_samples, gate_sample(in_data_i)};
    end
  end

  task automatic apb_access(input bit wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PaddrWidth'(4 * idx);
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(input int idx);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (idx == int'(RegChunkSize)) report_field("chunk_size", int'(chunk_cfg), int'(rd));
    else report_field("threshold", int'(thr_cfg), int'(rd));
  endtask

  // Write a register with random junk above its width, then read it back
  task automatic set_config(input int idx, input int unsigned value);
    logic [31:0] wdata;
    logic [31:0] rd;
    wdata = value;
    if (idx == int'(RegChunkSize)) begin
      wdata[31:ChunkSizeWidth] = (32-ChunkSizeWidth)'($urandom());
      chunk_cfg = wdata[ChunkSizeWidth-1:0];
    end else begin
      wdata[31:ThresholdWidth] = (32-ThresholdWidth)'($urandom());
      thr_cfg = wdata[ThresholdWidth-1:0];
    end
    apb_access(1'b1, idx, wdata, rd);
    check_reg(idx);
  endtask

  // Wait until every transaction has drained, then let the pipeline empty
  task automatic settle();
    while (word_backlog.size() != 0 || in_valid_i || awaited_samples.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic push_raw(input logic [15:0] raw);
    in_item_t it;
    it.kind = KindSample;
    it.raw_word = raw;
    word_backlog = {word_backlog, it};
  endtask

  // Sample whose 13-bit code is given; the bits above the code are random
  task automatic push_code(input int code);
    logic [15:0] c;
    c[12:0] = code[12:0];
    c[15:13] = 3'($urandom_range(0, 7));
    push_raw(mirror16(c));
  endtask

  task automatic push_start();
    in_item_t it;
    it.kind = KindStart;
    it.raw_word = 16'($urandom());
    word_backlog = {word_backlog, it};
  endtask

  task automatic add_random_items(input int n);
    int d;
    int code;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 3) begin
        push_start();
      end else begin
        case ($urandom_range(0, 2))
          0: push_raw(16'($urandom()));
          1: push_code(SilenceCode + $urandom_range(0, 80) - 40);
          default: begin
            // aim at the threshold boundary
            d = (int'(thr_cfg) * 2) / 15 + $urandom_range(0, 2) - 1;
            code = $urandom_range(0, 1) ? SilenceCode + d : SilenceCode - d;
            if (code < 0) code = 0;
            if (code > 'h1fff) code = 'h1fff;
            push_code(code);
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int unsigned chunk_pick;
    int unsigned thr_pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(int'(RegChunkSize));
    check_reg(int'(RegThreshold));

    // Directed: extremes, rounding toward zero, threshold boundary, start
    set_config(int'(RegChunkSize), 3);
    set_config(int'(RegThreshold), 7);
    @(negedge clk_i);
    push_start();
    push_raw(16'h0000);
    push_raw(16'hffff);
    push_code(SilenceCode);
    push_code(SilenceCode - 1);
    push_code(SilenceCode + 1);
    push_code(SilenceCode + 2);
    push_code(SilenceCode - 2);
    push_code(SilenceCode);
    push_code(SilenceCode);
    push_code(SilenceCode);
    push_code(SilenceCode + 2);
    push_start();
    push_code(SilenceCode);
    push_code(SilenceCode - 2);
    push_raw(16'h8000);
    push_raw(16'h0001);
    settle();

    // Count builds up without audio, then the chunk size drops below it
    set_config(int'(RegChunkSize), 8);
    @(negedge clk_i);
    push_start();
    repeat (5) push_code(SilenceCode);
    settle();
    set_config(int'(RegChunkSize), 2);
    @(negedge clk_i);
    push_code(SilenceCode + 3);
    repeat (3) push_code(SilenceCode);
    settle();

    // Zero chunk size and zero threshold
    set_config(int'(RegChunkSize), 0);
    set_config(int'(RegThreshold), 0);
    @(negedge clk_i);
    push_code(SilenceCode);
    push_code(SilenceCode + 1);
    push_code(SilenceCode);
    push_code(SilenceCode - 1);
    push_code(SilenceCode - 1);
    add_random_items(20);
    settle();

    // Quiet run grows after audio, streamed without gaps
    set_config(int'(RegChunkSize), 1023);
    set_config(int'(RegThreshold), 2);
    @(negedge clk_i);
    push_start();
    push_code(SilenceCode + 4);
    repeat (48) push_code(SilenceCode);
    push_code(SilenceCode - 4);
    repeat (3) push_code(SilenceCode);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin chunk_pick = 1; thr_pick = 2; end
        1: begin chunk_pick = 1023; thr_pick = 0; end
        2: begin chunk_pick = $urandom_range(2, 12); thr_pick = $urandom_range(0, 200); end
        3: begin chunk_pick = 1000; thr_pick = 32767; end
        4: begin chunk_pick = $urandom_range(1, 6); thr_pick = $urandom(); end
        5: begin chunk_pick = 0; thr_pick = $urandom_range(0, 40); end
        6: begin chunk_pick = $urandom(); thr_pick = 2; end
        default: begin chunk_pick = 4; thr_pick = 7; end
      endcase
      set_config(int'(RegChunkSize), chunk_pick);
      set_config(int'(RegThreshold), thr_pick);
      @(negedge clk_i);
      tx_mode <= (p % 2 == 1 && p != 3) ? TxBursty : TxStream;
      case (p % 3)
        0: rx_mode <= RxPattern;
        1: rx_mode <= RxRandom;
        default: rx_mode <= RxFree;
      endcase
      // hold the receiver off while the sender streams, so the core backs up
      if (p == 3) hold_request <= 1'b1;
      add_random_items(225);
      settle();
    end

    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
